// ----- design/ufd_pkg.sv -----
// Package for the URL form decoder: result word types, decoder constants
// and the hex digit helper functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ufd_pkg;

    typedef enum logic [1:0] {
        KIND_DATA     = 2'd0,
        KIND_NAME_END = 2'd1,
        KIND_PAIR_END = 2'd2,
        KIND_STR_END  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_FIRST  = 2'd1,
        PH_SECOND = 2'd2
    } phase_t;

    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_BAR     = 8'h7C;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_EOF     = 8'hFF;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_F    = 8'h46;
    localparam logic [7:0] CH_LO_A    = 8'h61;
    localparam logic [7:0] CH_LO_F    = 8'h66;
    localparam logic [7:0] HEX_TEN    = 8'd10;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0] data;
        kind_t      kind;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } dec_t;

    function automatic logic hex_ok(input logic [7:0] c);
        logic ok;
        ok = (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_UP_A && c <= CH_UP_F) ||
             (c >= CH_LO_A && c <= CH_LO_F);
        return ok;
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            v = c - CH_ZERO;
        end else if (c >= CH_LO_A && c <= CH_LO_F) begin
            v = c - CH_LO_A + HEX_TEN;
        end else if (c >= CH_UP_A && c <= CH_UP_F) begin
            v = c - CH_UP_A + HEX_TEN;
        end
        return v[3:0];
    endfunction

endpackage

`default_nettype wire

// ----- design/ufd_in_reg.sv -----
// Input register of the URL form decoder: holds one raw byte until the
// decoder consumes it. Depends on nothing but the clock and reset.
`timescale 1ns / 1ps
`default_nettype none

module ufd_in_reg (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_in_byte,
    input  wire logic       consume,
    output logic            hold_valid,
    output logic [7:0]      hold_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign s_ready    = !valid_reg || consume;
    assign hold_valid = valid_reg;
    assign hold_byte  = byte_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (consume) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_in_byte;
        end
    end

endmodule

`default_nettype wire

// ----- design/ufd_decode.sv -----
// Decoder of the URL form decoder: escape state and the per-byte decode
// into up to two result words. Depends on ufd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ufd_decode (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic [7:0] in_byte,
    input  wire logic       consume,
    output ufd_pkg::dec_t   dec
);

    ufd_pkg::phase_t phase_reg;
    ufd_pkg::phase_t phase_next;
    logic [3:0]      nibble_reg;
    logic [3:0]      nibble_next;
    logic            is_hex_reg;
    logic            is_hex_next;

    always_comb begin
        dec         = '0;
        dec.r0.kind = ufd_pkg::KIND_DATA;
        dec.r1.kind = ufd_pkg::KIND_DATA;
        phase_next  = ufd_pkg::PH_IDLE;
        nibble_next = nibble_reg;
        is_hex_next = is_hex_reg;
        if ((phase_reg == ufd_pkg::PH_FIRST || phase_reg == ufd_pkg::PH_SECOND) &&
            in_byte == ufd_pkg::CH_NUL) begin
            dec.count   = 2'd2;
            dec.r0      = '{data: ufd_pkg::CH_SPACE, kind: ufd_pkg::KIND_DATA, last: 1'b0};
            dec.r1      = '{data: 8'd0, kind: ufd_pkg::KIND_STR_END, last: 1'b1};
            nibble_next = 4'd0;
            is_hex_next = 1'b0;
        end else begin
            case (phase_reg)
                ufd_pkg::PH_FIRST: begin
                    dec.count   = 2'd0;
                    phase_next  = ufd_pkg::PH_SECOND;
                    nibble_next = ufd_pkg::hex_val(in_byte);
                    is_hex_next = ufd_pkg::hex_ok(in_byte);
                end
                ufd_pkg::PH_SECOND: begin
                    dec.count   = 2'd1;
                    dec.r0.last = 1'b1;
                    dec.r0.data = ufd_pkg::CH_SPACE;
                    if (is_hex_reg && ufd_pkg::hex_ok(in_byte)) begin
                        dec.r0.data = {nibble_reg, ufd_pkg::hex_val(in_byte)};
                    end
                    nibble_next = 4'd0;
                    is_hex_next = 1'b0;
                end
                default: begin
                    dec.count   = 2'd1;
                    dec.r0.last = 1'b1;
                    case (in_byte)
                        ufd_pkg::CH_PLUS: begin
                            dec.r0.data = ufd_pkg::CH_SPACE;
                        end
                        ufd_pkg::CH_EQUAL: begin
                            dec.r0.kind = ufd_pkg::KIND_NAME_END;
                        end
                        ufd_pkg::CH_AMP, ufd_pkg::CH_BAR: begin
                            dec.r0.kind = ufd_pkg::KIND_PAIR_END;
                        end
                        ufd_pkg::CH_NUL, ufd_pkg::CH_EOF: begin
                            dec.r0.kind = ufd_pkg::KIND_STR_END;
                            nibble_next = 4'd0;
                            is_hex_next = 1'b0;
                        end
                        ufd_pkg::CH_PERCENT: begin
                            dec.count   = 2'd0;
                            dec.r0.last = 1'b0;
                            phase_next  = ufd_pkg::PH_FIRST;
                            nibble_next = 4'd0;
                            is_hex_next = 1'b0;
                        end
                        default: begin
                            dec.r0.data = in_byte;
                        end
                    endcase
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= ufd_pkg::PH_IDLE;
            nibble_reg <= 4'd0;
            is_hex_reg <= 1'b0;
        end else if (consume) begin
            phase_reg  <= phase_next;
            nibble_reg <= nibble_next;
            is_hex_reg <= is_hex_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/ufd_out_queue.sv -----
// Two-word result queue of the URL form decoder. Takes up to two words per push
// and presents one word per cycle while m_ready is high. Depends on ufd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ufd_out_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push_valid,
    input  wire ufd_pkg::dec_t push_dec,
    output logic               push_ok,
    output logic               m_valid,
    input  wire logic          m_ready,
    output ufd_pkg::result_t   head
);

    localparam logic [2:0] DEPTH = 3'(ufd_pkg::QUEUE_DEPTH);

    logic [1:0]       cnt_reg;
    logic [1:0]       cnt_next;
    ufd_pkg::result_t slot0_reg;
    ufd_pkg::result_t slot0_next;
    ufd_pkg::result_t slot1_reg;
    ufd_pkg::result_t slot1_next;
    logic             pop;
    logic             push;
    logic [1:0]       cnt_after_pop;
    logic [2:0]       cnt_sum;

    assign m_valid       = (cnt_reg != 2'd0);
    assign head          = slot0_reg;
    assign pop           = m_valid && m_ready;
    assign cnt_after_pop = cnt_reg - {1'b0, pop};
    assign cnt_sum       = {1'b0, cnt_after_pop} + {1'b0, push_dec.count};
    assign push_ok       = (cnt_sum <= DEPTH);
    assign push          = push_valid && push_ok;

    always_comb begin
        slot0_next = pop ? slot1_reg : slot0_reg;
        slot1_next = slot1_reg;
        cnt_next   = cnt_after_pop;
        if (push) begin
            cnt_next = cnt_sum[1:0];
            if (cnt_after_pop == 2'd0) begin
                slot0_next = push_dec.r0;
                slot1_next = push_dec.r1;
            end else if (cnt_after_pop == 2'd1) begin
                slot1_next = push_dec.r0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

`default_nettype wire

// ----- design/url_form_decoder.sv -----
// URL form decoder, top level: decodes a form-urlencoded byte stream into
// data bytes and name, pair and string end markers. Depends on ufd_pkg,
// ufd_in_reg, ufd_decode and ufd_out_queue.
//
// One input word is taken per cycle when the result side keeps up. A byte
// passes the input register, is decoded in the cycle it is held there and
// lands in a two-word result queue, from whose registers its first result
// word is offered. A '%' and the first escape digit give no result. A zero
// byte inside an escape gives two results, a space and then the string end.
`timescale 1ns / 1ps
`default_nettype none

module url_form_decoder (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_in_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_byte,
    output logic [1:0]      m_kind,
    output logic            m_last
);

    logic             hold_valid;
    logic [7:0]       hold_byte;
    logic             push_ok;
    logic             consume;
    ufd_pkg::dec_t    dec;
    ufd_pkg::result_t head;

    assign consume = hold_valid && push_ok;

    ufd_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .consume    (consume),
        .hold_valid (hold_valid),
        .hold_byte  (hold_byte)
    );

    ufd_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_byte (hold_byte),
        .consume (consume),
        .dec     (dec)
    );

    ufd_out_queue u_out_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (hold_valid),
        .push_dec   (dec),
        .push_ok    (push_ok),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .head       (head)
    );

    assign m_out_byte = head.data;
    assign m_kind     = head.kind;
    assign m_last     = head.last;

`ifndef SYNTH
    a_marker_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != ufd_pkg::KIND_DATA |-> m_out_byte == 8'd0)
        else $error("marker word carries a nonzero byte");

    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == ufd_pkg::KIND_STR_END |-> m_last)
        else $error("string end word is not flagged last");

    a_pair_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> m_valid && m_kind == ufd_pkg::KIND_STR_END)
        else $error("first word of a pair not followed by string end");
`endif

endmodule

`default_nettype wire
